// File: rtl/dhb_pkg.sv
// Shared types and constants for the decimating history buffer.
// No dependencies; every other file of the block but dhb_ram imports this package.
package dhb_pkg;

   // Store geometry
   localparam int HISTORY_DEPTH = 64;
   localparam int HALF_DEPTH    = HISTORY_DEPTH / 2;
   localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
   localparam int FILL_W        = ADDR_W + 1;
   localparam int HALF_CNT_W    = $clog2(HALF_DEPTH + 1);

   // Field widths
   localparam int VALUE_W      = 24;
   localparam int SLOT_W       = 6;
   localparam int FILL_LEVEL_W = 7;
   localparam int INTERVAL_W   = 16;
   localparam int SUM_W        = 48;
   localparam int TERMS_W      = 17;
   localparam int CMP_W        = ((ADDR_W > SLOT_W) ? ADDR_W : SLOT_W) + 1;
   localparam int DIV_CNT_W    = $clog2(SUM_W + 1);

   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX   = '1;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1);

   // Operation codes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_COMPACT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                        stored;
      logic signed [VALUE_W-1:0]   result_value;
      logic [SLOT_W-1:0]           slot;
      logic                        slot_valid;
      logic [FILL_LEVEL_W-1:0]     fill_level;
      logic [INTERVAL_W-1:0]       interval;
   } result_type;

endpackage

// File: rtl/dhb_req_if.sv
// Request channel of the decimating history buffer: valid/ready plus command payload.
// Depends on dhb_pkg for field widths.
interface dhb_req_if;
   import dhb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                operation;
   logic signed [VALUE_W-1:0] sample_value;
   logic [SLOT_W-1:0]         read_slot;

   modport source (output valid, output operation, output sample_value, output read_slot,
                   input ready);
   modport sink   (input valid, input operation, input sample_value, input read_slot,
                   output ready);
endinterface

// File: rtl/dhb_rsp_if.sv
// Response channel of the decimating history buffer: valid/ready plus result payload.
// Depends on dhb_pkg for field widths.
interface dhb_rsp_if;
   import dhb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      stored;
   logic signed [VALUE_W-1:0] result_value;
   logic [SLOT_W-1:0]         slot;
   logic                      slot_valid;
   logic [FILL_LEVEL_W-1:0]   fill_level;
   logic [INTERVAL_W-1:0]     interval;

   modport source (output valid, output stored, output result_value, output slot,
                   output slot_valid, output fill_level, output interval, input ready);
   modport sink   (input valid, input stored, input result_value, input slot,
                   input slot_valid, input fill_level, input interval, output ready);
endinterface

// File: rtl/dhb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module dhb_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/dhb_divider.sv
// Radix-2 restoring divider: signed running sum over unsigned term count,
// quotient truncated toward zero and cut to the low VALUE_W bits. Uses dhb_pkg.
module dhb_divider import dhb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SUM_W-1:0]   dividend,
   input  logic [TERMS_W-1:0]        divisor,
   output logic                      done,
   output logic signed [VALUE_W-1:0] quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]         quot_ff, quot_in;
   logic [TERMS_W-1:0]       rem_ff, rem_in;
   logic [TERMS_W-1:0]       div_ff, div_in;
   logic                     neg_ff, neg_in;
   logic                     zero_ff, zero_in;
   logic [VALUE_W-1:0]       raw_ff, raw_in;
   logic [TERMS_W:0]         shifted;
   logic [TERMS_W:0]         diff;
   logic [VALUE_W-1:0]       quot_low;

   // One quotient bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      raw_in   = raw_ff;
      shifted  = {rem_ff, quot_ff[SUM_W-1]};
      diff     = shifted - {1'b0, div_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(SUM_W);
         neg_in   = dividend[SUM_W-1];
         quot_in  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in   = '0;
         div_in   = divisor;
         zero_in  = (divisor == '0);
         raw_in   = dividend[VALUE_W-1:0];
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in  = diff[TERMS_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[TERMS_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      raw_ff  <= raw_in;
   end

   // Apply the sign; a zero count passes the sum through
   assign quot_low = neg_ff ? (~quot_ff[VALUE_W-1:0] + 1'b1) : quot_ff[VALUE_W-1:0];
   assign quotient = zero_ff ? raw_ff : quot_low;
   assign done     = done_ff;

endmodule

// File: rtl/decimating_history_buffer_core.sv
// Decimating history buffer. Each add beat folds a Q15.8 sample into a running sum;
// every interval+1 adds the sum is divided by its term count (toward zero) and the
// average goes into the next slot of a 64-entry history RAM. When the RAM fills, the
// interval grows by one (up to 65535), the even slots are packed into the lower half
// and filling resumes at the midpoint. Items are taken one at a time. An add that stores
// nothing, a clear or an ignored code passes from idle to the done state, and a read
// passes the read state first; with the output register free, the done state hands the
// result over and the block returns to idle for the next request. An add that stores
// waits in the divide state for the 48-step divider; an add that fills the store also
// runs the compaction walk over the single RAM read port before the done state.
// A response waiting on rsp_if does not block acceptance of the next request.
// Depends on dhb_pkg, dhb_req_if, dhb_rsp_if, dhb_ram and dhb_divider.
module decimating_history_buffer_core import dhb_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   dhb_req_if.sink   req_if,
   dhb_rsp_if.source rsp_if
);

   state_type                 state_ff, state_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [INTERVAL_W-1:0]     step_ff, step_in;
   logic [INTERVAL_W-1:0]     interval_ff, interval_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [TERMS_W-1:0]        terms_ff, terms_in;
   logic [HISTORY_DEPTH-1:0]  entry_ok_ff, entry_ok_in;
   logic                      out_valid_ff, out_valid_in;
   logic [HALF_CNT_W-1:0]     cmp_cnt_ff, cmp_cnt_in;
   result_type                res_ff, res_in;
   result_type                out_ff, out_in;
   logic [ADDR_W-1:0]         rd_addr_ff, rd_addr_in;
   logic                      rd_range_ff, rd_range_in;
   logic [SLOT_W-1:0]         rd_slot_ff, rd_slot_in;

   logic                      ram_wr_en;
   logic [ADDR_W-1:0]         ram_wr_addr;
   logic [VALUE_W-1:0]        ram_wr_data;
   logic                      ram_rd_en;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic [VALUE_W-1:0]        ram_rd_data;
   logic [VALUE_W-1:0]        ram_word;

   logic                      div_start;
   logic                      div_done;
   logic signed [VALUE_W-1:0] div_quot;

   logic signed [SUM_W-1:0]   sum_next;
   logic [TERMS_W-1:0]        terms_next;
   logic [CMP_W-1:0]          rslot_ext;
   logic [FILL_W-1:0]         fill_inc;
   logic [FILL_W-1:0]         fill_new;
   logic [INTERVAL_W-1:0]     interval_new;

   dhb_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (HISTORY_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_history (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   dhb_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(sum_next),
      .divisor (terms_next),
      .done    (div_done),
      .quotient(div_quot)
   );

   // Never-written entries read as zero
   assign ram_word   = entry_ok_ff[rd_addr_ff] ? ram_rd_data : '0;
   assign sum_next   = sum_ff + {{(SUM_W - VALUE_W){req_if.sample_value[VALUE_W-1]}},
                                 req_if.sample_value};
   assign terms_next = terms_ff + 1'b1;
   assign rslot_ext  = CMP_W'(req_if.read_slot);
   assign fill_inc   = fill_ff + 1'b1;

   // Sequencer: next state, RAM accesses and result assembly
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      step_in      = step_ff;
      interval_in  = interval_ff;
      sum_in       = sum_ff;
      terms_in     = terms_ff;
      entry_ok_in  = entry_ok_ff;
      out_valid_in = out_valid_ff;
      cmp_cnt_in   = cmp_cnt_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rd_addr_in   = rd_addr_ff;
      rd_range_in  = rd_range_ff;
      rd_slot_in   = rd_slot_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      div_start    = 1'b0;
      req_if.ready = 1'b0;
      fill_new     = fill_inc;
      interval_new = interval_ff;

      // Drop the response once taken
      if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               res_in            = '0;
               res_in.fill_level = FILL_LEVEL_W'(fill_ff);
               res_in.interval   = interval_ff;
               state_in          = ST_DONE;
               case (req_if.operation)
                  OP_ADD: begin
                     sum_in   = sum_next;
                     terms_in = terms_next;
                     if (step_ff >= interval_ff) begin
                        step_in   = '0;
                        div_start = 1'b1;
                        state_in  = ST_DIVIDE;
                     end else begin
                        step_in = step_ff + 1'b1;
                     end
                  end
                  OP_READ: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = rslot_ext[ADDR_W-1:0];
                     rd_addr_in  = rslot_ext[ADDR_W-1:0];
                     rd_range_in = (rslot_ext < CMP_W'(HISTORY_DEPTH));
                     rd_slot_in  = req_if.read_slot;
                     state_in    = ST_READ;
                  end
                  OP_CLEAR: begin
                     fill_in     = '0;
                     step_in     = '0;
                     interval_in = INTERVAL_RESET;
                     sum_in      = '0;
                     terms_in    = '0;
                     entry_ok_in = '0;
                     res_in.fill_level = '0;
                     res_in.interval   = INTERVAL_RESET;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_READ: begin
            res_in.stored       = 1'b0;
            res_in.result_value = rd_range_ff ? ram_word : '0;
            res_in.slot         = rd_slot_ff;
            res_in.slot_valid   = rd_range_ff && (FILL_W'(rd_addr_ff) < fill_ff);
            state_in            = ST_DONE;
         end

         ST_DIVIDE: begin
            if (div_done) begin
               sum_in   = {{(SUM_W - VALUE_W){div_quot[VALUE_W-1]}}, div_quot};
               terms_in = TERMS_W'(1);
               if (fill_ff < FILL_W'(HISTORY_DEPTH)) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = fill_ff[ADDR_W-1:0];
                  ram_wr_data = div_quot;
                  entry_ok_in[fill_ff[ADDR_W-1:0]] = 1'b1;
               end
               if (fill_inc >= FILL_W'(HISTORY_DEPTH)) begin
                  if (interval_ff != INTERVAL_MAX) begin
                     interval_new = interval_ff + 1'b1;
                  end
                  fill_new   = FILL_W'(HALF_DEPTH);
                  cmp_cnt_in = '0;
                  state_in   = ST_COMPACT;
               end else begin
                  state_in = ST_DONE;
               end
               fill_in             = fill_new;
               interval_in         = interval_new;
               res_in.stored       = 1'b1;
               res_in.result_value = div_quot;
               res_in.slot         = SLOT_W'(fill_ff);
               res_in.slot_valid   = (fill_ff < fill_new);
               res_in.fill_level   = FILL_LEVEL_W'(fill_new);
               res_in.interval     = interval_new;
            end
         end

         ST_COMPACT: begin
            // Read slot 2k while writing slot k-1 with the word read last cycle
            if (cmp_cnt_ff < HALF_CNT_W'(HALF_DEPTH)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(cmp_cnt_ff) << 1;
               rd_addr_in  = ADDR_W'(cmp_cnt_ff) << 1;
               cmp_cnt_in  = cmp_cnt_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
            if (cmp_cnt_ff != '0) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = ADDR_W'(cmp_cnt_ff - 1'b1);
               ram_wr_data = ram_word;
               entry_ok_in[ADDR_W'(cmp_cnt_ff - 1'b1)] = 1'b1;
            end
         end

         ST_DONE: begin
            // Hand the result to the output register when it is free
            if (!out_valid_ff || rsp_if.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         step_ff      <= '0;
         interval_ff  <= INTERVAL_RESET;
         sum_ff       <= '0;
         terms_ff     <= '0;
         entry_ok_ff  <= '0;
         out_valid_ff <= 1'b0;
         cmp_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         interval_ff  <= interval_in;
         sum_ff       <= sum_in;
         terms_ff     <= terms_in;
         entry_ok_ff  <= entry_ok_in;
         out_valid_ff <= out_valid_in;
         cmp_cnt_ff   <= cmp_cnt_in;
      end
      res_ff      <= res_in;
      out_ff      <= out_in;
      rd_addr_ff  <= rd_addr_in;
      rd_range_ff <= rd_range_in;
      rd_slot_ff  <= rd_slot_in;
   end

   // Drive the response channel
   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.stored       = out_ff.stored;
   assign rsp_if.result_value = out_ff.result_value;
   assign rsp_if.slot         = out_ff.slot;
   assign rsp_if.slot_valid   = out_ff.slot_valid;
   assign rsp_if.fill_level   = out_ff.fill_level;
   assign rsp_if.interval     = out_ff.interval;

endmodule

// File: tb/testbench.sv
// Self-checking bench for decimating_history_buffer_core: directed table, then random beats.
// A shadow of the history store predicts every untyped response. Depends on dhb_pkg and both channel
// interfaces.
module testbench import dhb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Code that the block accepts and ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int DIRECTED_ROWS   = 24;
   localparam int PHASE_BEATS     = 370;
   localparam int PRESSURE_BEATS  = 12;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QUIET_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 200;
   localparam int MAX_REPORTS     = 10;

   typedef struct {
      logic [1:0]                operation;
      logic signed [VALUE_W-1:0] sample_value;
      logic [SLOT_W-1:0]         read_slot;
      bit                        typed;
      result_type                want;
   } stim_row_type;

   logic clock;
   logic reset;

   dhb_req_if req_if ();
   dhb_rsp_if rsp_if ();

   decimating_history_buffer_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // Shadow copy of the block state
   logic signed [VALUE_W-1:0] shadow_store [HISTORY_DEPTH];
   logic [FILL_LEVEL_W-1:0]   shadow_fill;
   logic [INTERVAL_W-1:0]     shadow_steps;
   logic [INTERVAL_W-1:0]     shadow_interval;
   logic signed [SUM_W-1:0]   shadow_sum;
   logic [TERMS_W-1:0]        shadow_terms;

   result_type   history_results_due [$];
   stim_row_type directed_rows [DIRECTED_ROWS];

   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_request;
   int hold_cycles_left;
   int quiet_cycles;
   int mismatch_count;

   always #1 clock = ~clock;

   function automatic void clear_shadow();
      foreach (shadow_store[i]) shadow_store[i] = '0;
      shadow_fill     = '0;
      shadow_steps    = '0;
      shadow_interval = INTERVAL_RESET;
      shadow_sum      = '0;
      shadow_terms    = '0;
   endfunction

   // Apply one request to the shadow state and return the response it must cause
   function automatic result_type predict_history_step(input logic [1:0] operation,
                                                       input logic signed [VALUE_W-1:0] sample,
                                                       input logic [SLOT_W-1:0] rslot);
      result_type                r;
      longint                    quotient;
      logic signed [VALUE_W-1:0] avg_value;
      int unsigned               slot_index;
      int                        idx;
      r = '0;
      case (operation)
         OP_ADD: begin
            shadow_sum   = shadow_sum + sample;
            shadow_terms = shadow_terms + 1'b1;
            if (shadow_steps >= shadow_interval) begin
               shadow_steps = '0;
               if (shadow_terms != 0)
                  quotient = longint'(shadow_sum) / longint'(shadow_terms);
               else
                  quotient = longint'(shadow_sum);
               avg_value    = quotient[VALUE_W-1:0];
               shadow_sum   = avg_value;
               shadow_terms = TERMS_W'(1);
               slot_index   = shadow_fill;
               shadow_store[slot_index] = avg_value;
               shadow_fill  = shadow_fill + 1'b1;
               r.stored       = 1'b1;
               r.result_value = avg_value;
               r.slot         = slot_index[SLOT_W-1:0];
               // Full store: widen the interval and pack even slots into the lower half
               if (shadow_fill >= HISTORY_DEPTH) begin
                  if (shadow_interval != INTERVAL_MAX)
                     shadow_interval = shadow_interval + 1'b1;
                  shadow_fill = FILL_LEVEL_W'(HALF_DEPTH);
                  for (idx = 0; idx < HALF_DEPTH; idx++)
                     shadow_store[idx] = shadow_store[2 * idx];
               end
               r.slot_valid = (slot_index < shadow_fill);
            end else begin
               shadow_steps = shadow_steps + 1'b1;
            end
         end
         OP_READ: begin
            r.slot = rslot;
            if (rslot < HISTORY_DEPTH) begin
               r.result_value = shadow_store[rslot];
               r.slot_valid   = (rslot < shadow_fill);
            end
         end
         OP_CLEAR: clear_shadow();
         default: ;
      endcase
      r.fill_level = shadow_fill;
      r.interval   = shadow_interval;
      return r;
   endfunction

   // Offer one request beat, wait for the handshake, then queue its response
   task automatic send_beat(input logic [1:0] operation,
                            input logic signed [VALUE_W-1:0] sample,
                            input logic [SLOT_W-1:0] rslot,
                            input bit typed,
                            input result_type want);
      result_type predicted;
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_if.valid        <= 1'b1;
      req_if.operation    <= operation;
      req_if.sample_value <= sample;
      req_if.read_slot    <= rslot;
      do @(posedge clock); while (!req_if.ready);
      predicted = predict_history_step(operation, sample, rslot);
      history_results_due.push_back(typed ? want : predicted);
   endtask

   // Random beats: mostly adds so the store fills and compacts, with reads and rare clears
   task automatic run_random_beats(input int count);
      logic [1:0]                operation;
      logic signed [VALUE_W-1:0] sample;
      logic [SLOT_W-1:0]         rslot;
      int                        pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(999);
         if (pick < 2)
            operation = OP_CLEAR;
         else if (pick < 22)
            operation = OP_UNUSED;
         else if (pick < 222)
            operation = OP_READ;
         else
            operation = OP_ADD;
         case ($urandom_range(9))
            4, 5:    sample = VALUE_W'($urandom_range(1024)) - 24'sd512;
            6:       sample = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            7:       sample = $urandom_range(1) ? 24'sh000000 : 24'shFFFFFF;
            8:       sample = 24'sh7FFFFF - VALUE_W'($urandom_range(255));
            9:       sample = 24'sh800000 + VALUE_W'($urandom_range(255));
            default: sample = VALUE_W'($urandom);
         endcase
         if (shadow_fill != 0 && $urandom_range(9) < 6)
            rslot = SLOT_W'($urandom_range(shadow_fill - 1));
         else
            rslot = SLOT_W'($urandom);
         send_beat(operation, sample, rslot, 1'b0, '0);
      end
   endtask

   task automatic check_history_result();
      result_type seen;
      result_type want;
      seen.stored       = rsp_if.stored;
      seen.result_value = rsp_if.result_value;
      seen.slot         = rsp_if.slot;
      seen.slot_valid   = rsp_if.slot_valid;
      seen.fill_level   = rsp_if.fill_level;
      seen.interval     = rsp_if.interval;
      if (history_results_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: response beat with nothing outstanding", $realtime);
      end else begin
         want = history_results_due.pop_front();
         if (seen.stored !== want.stored || seen.result_value !== want.result_value ||
             seen.slot !== want.slot || seen.slot_valid !== want.slot_valid ||
             seen.fill_level !== want.fill_level || seen.interval !== want.interval) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: mismatch exp stored=%0b value=%0d slot=%0d valid=%0b fill=%0d ivl=%0d",
                        $realtime, want.stored, $signed(want.result_value), want.slot,
                        want.slot_valid, want.fill_level, want.interval);
               $display("%0t:          got stored=%0b value=%0d slot=%0d valid=%0b fill=%0d ivl=%0d",
                        $realtime, seen.stored, $signed(seen.result_value), seen.slot,
                        seen.slot_valid, seen.fill_level, seen.interval);
            end
         end
      end
   endtask

   // Response side: check accepted beats, then stall at random or hold off on request
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         check_history_result();
      if (hold_cycles_left != 0) begin
         hold_cycles_left = hold_cycles_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request     = 1'b0;
         hold_cycles_left = HOLD_OFF_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Abort when neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.operation    = OP_ADD;
      req_if.sample_value = '0;
      req_if.read_slot    = '0;
      rsp_if.ready        = 1'b0;
      sender_idle_pct     = 0;
      receiver_stall_pct  = 0;
      hold_request        = 1'b0;
      hold_cycles_left    = 0;
      quiet_cycles        = 0;
      mismatch_count      = 0;
      clear_shadow();

      // operation, sample, read slot, typed, {stored, value, slot, valid, fill, interval}
      directed_rows = '{
         '{OP_READ,   24'sh000000,  6'd0, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd0, 16'd1}},
         '{OP_READ,   24'shFFFFFF, 6'd63, 1'b1, '{1'b0, 24'sh000000, 6'd63, 1'b0, 7'd0, 16'd1}},
         '{OP_UNUSED, 24'sh7FFFFF,  6'd5, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd0, 16'd1}},
         '{OP_CLEAR,  24'sh5A5A5A, 6'd42, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd0, 16'd1}},
         '{OP_ADD,    24'sh7FFFFF, 6'd63, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd0, 16'd1}},
         '{OP_ADD,    24'sh7FFFFF,  6'd0, 1'b1, '{1'b1, 24'sh7FFFFF, 6'd0, 1'b1, 7'd1, 16'd1}},
         '{OP_ADD,    24'sh800000, 6'd21, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd1, 16'd1}},
         '{OP_ADD,    24'sh800000,  6'd0, 1'b0, '0},
         '{OP_ADD,    24'shFFFFFF,  6'd0, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd2, 16'd1}},
         '{OP_ADD,    24'sh000000,  6'd0, 1'b0, '0},
         '{OP_ADD,    24'sh000100,  6'd0, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd3, 16'd1}},
         '{OP_ADD,    24'sh000001,  6'd0, 1'b0, '0},
         '{OP_ADD,    24'shFFFF00,  6'd0, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd4, 16'd1}},
         '{OP_ADD,    24'sh555555,  6'd0, 1'b0, '0},
         '{OP_ADD,    24'shAAAAAA,  6'd0, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd5, 16'd1}},
         '{OP_ADD,    24'sh000001,  6'd0, 1'b0, '0},
         '{OP_READ,   24'sh000000,  6'd0, 1'b1, '{1'b0, 24'sh7FFFFF, 6'd0, 1'b1, 7'd6, 16'd1}},
         '{OP_READ,   24'sh000000,  6'd6, 1'b1, '{1'b0, 24'sh000000, 6'd6, 1'b0, 7'd6, 16'd1}},
         '{OP_READ,   24'shA5A5A5,  6'd1, 1'b0, '0},
         '{OP_CLEAR,  24'sh000000,  6'd0, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd0, 16'd1}},
         '{OP_READ,   24'sh000000,  6'd0, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd0, 16'd1}},
         '{OP_ADD,    24'shFFFFFF,  6'd0, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b0, 7'd0, 16'd1}},
         // minus one half truncates toward zero
         '{OP_ADD,    24'sh000000,  6'd0, 1'b1, '{1'b1, 24'sh000000, 6'd0, 1'b1, 7'd1, 16'd1}},
         '{OP_READ,   24'sh123456,  6'd0, 1'b1, '{1'b0, 24'sh000000, 6'd0, 1'b1, 7'd1, 16'd1}}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table with both sides free-running
      foreach (directed_rows[r])
         send_beat(directed_rows[r].operation, directed_rows[r].sample_value,
                   directed_rows[r].read_slot, directed_rows[r].typed, directed_rows[r].want);

      // Hold off the response side and keep offering until the input backs up
      hold_request = 1'b1;
      run_random_beats(PRESSURE_BEATS);

      // Pause the sender until every outstanding response has drained
      req_if.valid <= 1'b0;
      while (history_results_due.size() != 0) @(posedge clock);

      run_random_beats(PHASE_BEATS);
      sender_idle_pct = 85;
      run_random_beats(PHASE_BEATS);
      sender_idle_pct    = 0;
      receiver_stall_pct = 85;
      run_random_beats(PHASE_BEATS);
      sender_idle_pct    = 29;
      receiver_stall_pct = 29;
      run_random_beats(PHASE_BEATS);

      req_if.valid <= 1'b0;
      while (history_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && history_results_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
